// File: sv/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the sorted key/value table
// Field widths, action and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 7;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_DECIDE,
    S_UP_CHK,
    S_UP_WR,
    S_DN_CHK,
    S_DN_WR,
    S_LOOK,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    ADR_IDX,
    ADR_IDX_M1,
    ADR_POS
  } addr_sel_e;

  typedef enum logic [1:0] {
    RV_ZERO,
    RV_ONES,
    RV_READ
  } res_val_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT,
    IDX_POS_INC
  } idx_op_e;

  typedef struct packed {
    logic      load_req;
    idx_op_e   idx_op;
    logic      save_pos;
    logic      pos_hit;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      wr_key;
    logic      wr_val;
    addr_sel_e wr_sel;
    logic      wr_from_rd;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_load;
    status_e   res_status;
    res_val_e  res_val;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    hit;
    logic    full;
    logic    idx_at_count;
    logic    idx_at_pos;
    logic    key_ge;
    logic    key_eq;
    logic    out_busy;
  } dp_stat_t;

endpackage

// File: sv/skvt_if.sv
// ----------------------------------------------------------------------------
// skvt request and response channels
// Valid/ready channels carrying one request or one result per transaction.
// ----------------------------------------------------------------------------
interface skvt_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [skvt_pkg::KEY_W-1:0]  key;
  logic [skvt_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface skvt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [skvt_pkg::VALUE_W-1:0] value_out;
  logic [skvt_pkg::COUNT_W-1:0] count;

  modport source (output valid, status, value_out, count, input ready);
  modport sink   (input valid, status, value_out, count, output ready);
endinterface

// File: sv/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core: sorted key/value table
// Up to CAPACITY unique keys kept in ascending order with a value each.
// ----------------------------------------------------------------------------
// usage
//   req_i: one request per transaction (action, key, value); rsp_o: one
//   result per request (status, value_out, count), in request order
//   actions: add or update, set value if present, remove, lookup
//   one request is worked on at a time; req_i.ready is high only while idle
//   time from accept to rsp_o.valid grows with the number of entries below
//   the key and of entries moved; the next request is taken once the result
//   has moved to the output register, which happens only while rsp_o is free
//   every read goes through the single read port of the key/value memories,
//   one read then one compare per scanned entry, one read then one write
//   per shifted entry
//   lookup hit takes one extra memory read
//   the result sits in an output register, so the next request is taken
//   while rsp_o waits; a further result waits in the sequencer until the
//   output register is free
//   reset empties the table at once (count cleared, memories left as is,
//   only slots below count are ever read) and drops any pending result
// ----------------------------------------------------------------------------
module sorted_key_value_table_core #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skvt_req_if.sink   req_i,
  skvt_rsp_if.source rsp_o
);

  // command and status bundles between sequencer and datapath
  skvt_pkg::dp_cmd_t  dp_cmd;
  skvt_pkg::dp_stat_t dp_stat;
  logic [1:0]         rsp_status;

  // sequencer: scan, decide, shift, respond
  skvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // storage, pointers and output register
  skvt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .action_i     (req_i.action),
    .key_i        (req_i.key),
    .value_i      (req_i.value),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_status),
    .out_value_o  (rsp_o.value_out),
    .out_count_o  (rsp_o.count)
  );

  assign rsp_o.status = rsp_status;

endmodule

// File: sv/skvt_datapath.sv
// ----------------------------------------------------------------------------
// skvt_datapath: storage, pointers and result registers
// Key and value memories in ascending key order, scan/shift pointer, entry
// count, the held request and the output register.
// ----------------------------------------------------------------------------
module skvt_datapath #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  skvt_pkg::dp_cmd_t            cmd_i,
  output skvt_pkg::dp_stat_t           stat_o,
  input  logic [1:0]                   action_i,
  input  logic [skvt_pkg::KEY_W-1:0]   key_i,
  input  logic [skvt_pkg::VALUE_W-1:0] value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   out_status_o,
  output logic [skvt_pkg::VALUE_W-1:0] out_value_o,
  output logic [skvt_pkg::COUNT_W-1:0] out_count_o
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  logic [skvt_pkg::KEY_W-1:0]   key_mem [CAPACITY];
  logic [skvt_pkg::VALUE_W-1:0] val_mem [CAPACITY];

  skvt_pkg::action_e            action_q;
  logic [skvt_pkg::KEY_W-1:0]   key_q;
  logic [skvt_pkg::VALUE_W-1:0] value_q;
  logic [skvt_pkg::KEY_W-1:0]   key_rd_q;
  logic [skvt_pkg::VALUE_W-1:0] val_rd_q;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q;
  logic             hit_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] rd_ptr, wr_ptr;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [skvt_pkg::KEY_W-1:0]   wr_key;
  logic [skvt_pkg::VALUE_W-1:0] wr_val;

  skvt_pkg::status_e            res_status_q;
  logic [skvt_pkg::VALUE_W-1:0] res_value_q, res_value_d;

  logic                         out_valid_q;
  skvt_pkg::status_e            out_status_q;
  logic [skvt_pkg::VALUE_W-1:0] out_value_q;
  logic [skvt_pkg::COUNT_W-1:0] out_count_q;

  assign idx_m1 = idx_q - 1'b1;

  always_comb begin
    case (cmd_i.rd_sel)
      skvt_pkg::ADR_IDX_M1: rd_ptr = idx_m1;
      skvt_pkg::ADR_POS:    rd_ptr = pos_q;
      default:              rd_ptr = idx_q;
    endcase
    case (cmd_i.wr_sel)
      skvt_pkg::ADR_IDX_M1: wr_ptr = idx_m1;
      skvt_pkg::ADR_POS:    wr_ptr = pos_q;
      default:              wr_ptr = idx_q;
    endcase
  end

  assign rd_addr = rd_ptr[ADDR_W-1:0];
  assign wr_addr = wr_ptr[ADDR_W-1:0];
  assign wr_key  = cmd_i.wr_from_rd ? key_rd_q : key_q;
  assign wr_val  = cmd_i.wr_from_rd ? val_rd_q : value_q;

  // memories: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (cmd_i.wr_val) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (cmd_i.rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      val_rd_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      action_q <= skvt_pkg::action_e'(action_i);
      key_q    <= key_i;
      value_q  <= value_i;
    end
    if (cmd_i.save_pos) begin
      pos_q <= idx_q;
      hit_q <= cmd_i.pos_hit;
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      skvt_pkg::IDX_CLR:     idx_d = '0;
      skvt_pkg::IDX_INC:     idx_d = idx_q + 1'b1;
      skvt_pkg::IDX_DEC:     idx_d = idx_m1;
      skvt_pkg::IDX_COUNT:   idx_d = count_q;
      skvt_pkg::IDX_POS_INC: idx_d = pos_q + 1'b1;
      default:               idx_d = idx_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    case (cmd_i.res_val)
      skvt_pkg::RV_ONES: res_value_d = '1;
      skvt_pkg::RV_READ: res_value_d = val_rd_q;
      default:           res_value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= res_value_d;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= skvt_pkg::COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.action       = action_q;
  assign stat_o.hit          = hit_q;
  assign stat_o.full         = (count_q == CNT_W'(CAPACITY));
  assign stat_o.idx_at_count = (idx_q == count_q);
  assign stat_o.idx_at_pos   = (idx_q == pos_q);
  assign stat_o.key_ge       = (key_rd_q >= key_q);
  assign stat_o.key_eq       = (key_rd_q == key_q);
  assign stat_o.out_busy     = out_valid_q & ~out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_count_o  = out_count_q;

endmodule

// File: sv/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// skvt_ctrl: request sequencer
// Scans for the sorted position, then updates, shifts up, shifts down or
// reads out, and hands the result to the output register.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  skvt_pkg::dp_stat_t stat_i,
  output skvt_pkg::dp_cmd_t  cmd_o
);

  skvt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skvt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      skvt_pkg::S_IDLE: begin
        if (req_valid_i) state_d = skvt_pkg::S_SCAN;
      end
      skvt_pkg::S_SCAN: begin
        state_d = stat_i.idx_at_count ? skvt_pkg::S_DECIDE : skvt_pkg::S_CMP;
      end
      skvt_pkg::S_CMP: begin
        state_d = stat_i.key_ge ? skvt_pkg::S_DECIDE : skvt_pkg::S_SCAN;
      end
      skvt_pkg::S_DECIDE: begin
        state_d = skvt_pkg::S_RESP;
        case (stat_i.action)
          skvt_pkg::ACT_ADD: begin
            if (!stat_i.hit && !stat_i.full) state_d = skvt_pkg::S_UP_CHK;
          end
          skvt_pkg::ACT_REMOVE: begin
            if (stat_i.hit) state_d = skvt_pkg::S_DN_CHK;
          end
          skvt_pkg::ACT_LOOKUP: begin
            if (stat_i.hit) state_d = skvt_pkg::S_LOOK;
          end
          default: state_d = skvt_pkg::S_RESP;
        endcase
      end
      skvt_pkg::S_UP_CHK: begin
        state_d = stat_i.idx_at_pos ? skvt_pkg::S_RESP : skvt_pkg::S_UP_WR;
      end
      skvt_pkg::S_UP_WR:  state_d = skvt_pkg::S_UP_CHK;
      skvt_pkg::S_DN_CHK: begin
        state_d = stat_i.idx_at_count ? skvt_pkg::S_RESP : skvt_pkg::S_DN_WR;
      end
      skvt_pkg::S_DN_WR:  state_d = skvt_pkg::S_DN_CHK;
      skvt_pkg::S_LOOK:   state_d = skvt_pkg::S_RESP;
      skvt_pkg::S_RESP: begin
        if (!stat_i.out_busy) state_d = skvt_pkg::S_IDLE;
      end
      default: state_d = skvt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.idx_op     = skvt_pkg::IDX_HOLD;
    cmd_o.rd_sel     = skvt_pkg::ADR_IDX;
    cmd_o.wr_sel     = skvt_pkg::ADR_IDX;
    cmd_o.res_status = skvt_pkg::ST_OK;
    cmd_o.res_val    = skvt_pkg::RV_ZERO;
    req_ready_o      = 1'b0;
    case (state_q)
      skvt_pkg::S_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
        cmd_o.idx_op   = skvt_pkg::IDX_CLR;
      end
      skvt_pkg::S_SCAN: begin
        if (stat_i.idx_at_count) begin
          cmd_o.save_pos = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      skvt_pkg::S_CMP: begin
        if (stat_i.key_ge) begin
          cmd_o.save_pos = 1'b1;
          cmd_o.pos_hit  = stat_i.key_eq;
        end else begin
          cmd_o.idx_op = skvt_pkg::IDX_INC;
        end
      end
      skvt_pkg::S_DECIDE: begin
        cmd_o.res_load = 1'b1;
        case (stat_i.action)
          skvt_pkg::ACT_ADD: begin
            if (stat_i.hit) begin
              cmd_o.wr_val = 1'b1;
              cmd_o.wr_sel = skvt_pkg::ADR_POS;
            end else if (stat_i.full) begin
              cmd_o.res_status = skvt_pkg::ST_FULL;
            end else begin
              cmd_o.idx_op = skvt_pkg::IDX_COUNT;
            end
          end
          skvt_pkg::ACT_SET: begin
            if (stat_i.hit) begin
              cmd_o.wr_val = 1'b1;
              cmd_o.wr_sel = skvt_pkg::ADR_POS;
            end else begin
              cmd_o.res_status = skvt_pkg::ST_ABSENT;
            end
          end
          skvt_pkg::ACT_REMOVE: begin
            if (stat_i.hit) begin
              cmd_o.idx_op = skvt_pkg::IDX_POS_INC;
            end else begin
              cmd_o.res_status = skvt_pkg::ST_ABSENT;
            end
          end
          default: begin
            if (stat_i.hit) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = skvt_pkg::ADR_POS;
            end else begin
              cmd_o.res_status = skvt_pkg::ST_ABSENT;
              cmd_o.res_val    = skvt_pkg::RV_ONES;
            end
          end
        endcase
      end
      skvt_pkg::S_UP_CHK: begin
        if (stat_i.idx_at_pos) begin
          cmd_o.wr_key  = 1'b1;
          cmd_o.wr_val  = 1'b1;
          cmd_o.wr_sel  = skvt_pkg::ADR_POS;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skvt_pkg::ADR_IDX_M1;
        end
      end
      skvt_pkg::S_UP_WR: begin
        cmd_o.wr_key     = 1'b1;
        cmd_o.wr_val     = 1'b1;
        cmd_o.wr_from_rd = 1'b1;
        cmd_o.idx_op     = skvt_pkg::IDX_DEC;
      end
      skvt_pkg::S_DN_CHK: begin
        if (stat_i.idx_at_count) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      skvt_pkg::S_DN_WR: begin
        cmd_o.wr_key     = 1'b1;
        cmd_o.wr_val     = 1'b1;
        cmd_o.wr_from_rd = 1'b1;
        cmd_o.wr_sel     = skvt_pkg::ADR_IDX_M1;
        cmd_o.idx_op     = skvt_pkg::IDX_INC;
      end
      skvt_pkg::S_LOOK: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_val  = skvt_pkg::RV_READ;
      end
      skvt_pkg::S_RESP: begin
        cmd_o.out_load = ~stat_i.out_busy;
      end
      default: begin
        cmd_o.load_req = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/skvt_checker.sv
// ----------------------------------------------------------------------------
// skvt_checker: port-level checks of the sorted key/value table
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module skvt_checker #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [1:0]                   rsp_status_i,
  input logic [skvt_pkg::COUNT_W-1:0] rsp_count_i
);

  // a held result keeps its payload until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_count_i))
    else $error("response dropped or changed while stalled");

  // one request at a time: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  // entry count never goes beyond the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_count_i <= skvt_pkg::COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a dropped insert only when the table is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == skvt_pkg::ST_FULL
      |-> rsp_count_i == skvt_pkg::COUNT_W'(CAPACITY))
    else $error("full status with free slots");

endmodule

bind sorted_key_value_table_core skvt_checker #(
  .CAPACITY (CAPACITY)
) u_skvt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.count)
);

// File: verif/skvt_table_checker.sv
// ----------------------------------------------------------------------------
// skvt_table_checker: result checker for the sorted key/value table
// Watches the request and result channels, keeps its own copy of the table,
// works out the result of every accepted request and compares it field by
// field with the result that the block returns, in request order.
// ----------------------------------------------------------------------------
module skvt_table_checker
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skvt_req_if         req_i,
  skvt_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct {
    status_e             status;
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  // shadow table, ascending keys in slots 0 .. live_cnt-1
  logic [KEY_W-1:0]   key_tbl [CAPACITY];
  logic [VALUE_W-1:0] val_tbl [CAPACITY];
  int                 live_cnt;

  table_result_t      expected_results [$];
  table_result_t      want;
  int unsigned        fail_total = 0;

  function automatic table_result_t apply_request(action_e act, logic [KEY_W-1:0] k,
                                                  logic [VALUE_W-1:0] v);
    table_result_t r;
    int            hit_idx;
    int            below;
    r.status    = ST_OK;
    r.value_out = '0;
    hit_idx     = -1;
    below       = 0;
    for (int i = 0; i < live_cnt; i++) begin
      if (key_tbl[i] == k) hit_idx = i;
      if (key_tbl[i] < k) below++;
    end
    case (act)
      ACT_ADD: begin
        if (hit_idx >= 0) begin
          val_tbl[hit_idx] = v;
        end else if (live_cnt >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = live_cnt; i > below; i--) begin
            key_tbl[i] = key_tbl[i-1];
            val_tbl[i] = val_tbl[i-1];
          end
          key_tbl[below] = k;
          val_tbl[below] = v;
          live_cnt++;
        end
      end
      ACT_SET: begin
        if (hit_idx >= 0) val_tbl[hit_idx] = v;
        else r.status = ST_ABSENT;
      end
      ACT_REMOVE: begin
        if (hit_idx >= 0) begin
          for (int i = hit_idx; i + 1 < live_cnt; i++) begin
            key_tbl[i] = key_tbl[i+1];
            val_tbl[i] = val_tbl[i+1];
          end
          live_cnt--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        if (hit_idx >= 0) begin
          r.value_out = val_tbl[hit_idx];
        end else begin
          r.status    = ST_ABSENT;
          r.value_out = '1;
        end
      end
    endcase
    r.count = COUNT_W'(live_cnt);
    return r;
  endfunction

  // only the first ten failures are printed
  function automatic void log_failure(string msg);
    fail_total++;
    if (fail_total <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_cnt = 0;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(apply_request(action_e'(req_i.action), req_i.key,
                                                 req_i.value));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          log_failure($sformatf("result with none expected: status %0d value_out %h count %0d",
                                rsp_i.status, rsp_i.value_out, rsp_i.count));
        end else begin
          want = expected_results.pop_front();
          if (rsp_i.status !== want.status || rsp_i.value_out !== want.value_out ||
              rsp_i.count !== want.count) begin
            log_failure($sformatf({"result mismatch: status exp %0d got %0d, ",
                                   "value_out exp %h got %h, count exp %0d got %0d"},
                                  want.status, rsp_i.status, want.value_out,
                                  rsp_i.value_out, want.count, rsp_i.count));
          end
        end
      end
      pending_o    <= expected_results.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

// File: verif/sorted_key_value_table_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core_tb: testbench of the sorted key/value table
// A short directed sequence covers the empty table, the extreme keys and
// values and every action; random traffic then fills, churns and drains the
// table from a small key pool so that hits, misses and full-table drops are
// frequent. Both channels idle at random; the checker judges every result.
// ----------------------------------------------------------------------------
module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = skvt_pkg::CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1000;
  // a pool a bit larger than the table, so fill traffic reaches the full case
  localparam int unsigned POOL_SIZE    = 96;
  // worst case request latency with some margin
  localparam int unsigned DRAIN_CYCLES = 4 * TABLE_DEPTH + 16;

  // flavor of a random burst
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } traffic_mix_e;

  logic        clk_i;
  logic        rst_ni;
  logic        hold_rsp;
  int unsigned sent_cnt = 0;
  int unsigned fail_count;
  int unsigned pending;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  skvt_req_if req_ch ();
  skvt_rsp_if rsp_ch ();

  sorted_key_value_table_core #(
    .CAPACITY (TABLE_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  skvt_table_checker #(
    .CAPACITY (TABLE_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock and a single reset pulse at the start
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // mostly back to back, sometimes a short pause, rarely a long pause
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic action_e pick_action(traffic_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return action_e'(roll < 70 ? ACT_ADD : roll < 85 ? ACT_LOOKUP :
                                  roll < 95 ? ACT_SET : ACT_REMOVE);
      MIX_DRAIN: return action_e'(roll < 70 ? ACT_REMOVE : roll < 85 ? ACT_LOOKUP :
                                  roll < 90 ? ACT_SET : ACT_ADD);
      default:   return action_e'($urandom_range(0, 3));
    endcase
  endfunction

  // offer one request, hold it until the transaction, then maybe pause
  task automatic issue_request(input action_e act, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v, input bit quiet);
    int unsigned gap;
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_cnt++;
    gap = quiet ? 0 : idle_cycles();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // request side: directed sequence, random bursts, then the verdict
  initial begin : req_source
    traffic_mix_e       mix;
    int unsigned        burst;
    int unsigned        random_sent;
    int unsigned        roll;
    bit                 quiet;
    action_e            act;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_ADD;
    req_ch.key    = '0;
    req_ch.value  = '0;
    // extreme keys sit in the pool next to random ones
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    key_pool[4] = 32'h7fff_ffff;
    @(posedge rst_ni);
    @(posedge clk_i);

    // empty table: every search misses
    issue_request(ACT_LOOKUP, '0, '0, 1'b0);
    issue_request(ACT_REMOVE, '1, '0, 1'b0);
    issue_request(ACT_SET,    '0, '1, 1'b0);
    // inserts at the ends and in the middle
    issue_request(ACT_ADD, '0,           '0,           1'b0);
    issue_request(ACT_ADD, '1,           '1,           1'b0);
    issue_request(ACT_ADD, 32'h8000_0000, 32'h1234_5678, 1'b0);
    issue_request(ACT_ADD, 32'h0000_0001, 32'hffff_fffe, 1'b1);
    // add of a present key only updates its value
    issue_request(ACT_ADD,    '0, 32'h0000_0005, 1'b0);
    issue_request(ACT_LOOKUP, '0, '0, 1'b0);
    issue_request(ACT_LOOKUP, '1, '0, 1'b0);
    issue_request(ACT_SET,    32'h8000_0000, 32'ha5a5_5a5a, 1'b0);
    issue_request(ACT_LOOKUP, 32'h8000_0000, '0, 1'b0);
    issue_request(ACT_SET,    32'h7fff_ffff, '1, 1'b0);
    issue_request(ACT_LOOKUP, 32'h7fff_ffff, '0, 1'b0);
    // removes from the middle, the front and the back down to empty
    issue_request(ACT_REMOVE, 32'h8000_0000, '0, 1'b0);
    issue_request(ACT_REMOVE, '0,            '0, 1'b0);
    issue_request(ACT_REMOVE, 32'h0000_0001, '0, 1'b1);
    issue_request(ACT_REMOVE, '1,            '0, 1'b0);
    issue_request(ACT_LOOKUP, '1,            '0, 1'b0);
    issue_request(ACT_REMOVE, '1,            '0, 1'b0);

    // the first burst fills the table so the full case shows up early
    random_sent = 0;
    mix         = MIX_FILL;
    burst       = 200;
    quiet       = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      for (int n = 0; n < burst && random_sent < RANDOM_ITEMS; n++) begin
        act = pick_action(mix);
        // unknown keys only for misses, so drains can still empty the table
        if (act != ACT_ADD && $urandom_range(0, 9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        roll = $urandom_range(0, 19);
        v    = roll == 0 ? '0 : roll == 1 ? '1 : $urandom();
        issue_request(act, k, v, quiet);
        random_sent++;
      end
      mix   = traffic_mix_e'($urandom_range(0, 2));
      burst = $urandom_range(40, 160);
      quiet = ($urandom_range(0, 3) == 0);
    end
    req_ch.valid <= 1'b0;

    // pending_o is registered; after this edge it counts the last transaction too
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sorted_key_value_table_core_tb passed");
    end else begin
      $display("sorted_key_value_table_core_tb failed");
    end
    $finish;
  end

  // result side: calm stretches and stretches of random stalls, picked at random
  initial begin : rsp_sink
    int unsigned stretch_left;
    int unsigned stall_left;
    bit          calm;
    stretch_left = 0;
    stall_left   = 0;
    calm         = 1'b1;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stretch_left == 0) begin
        calm         = ($urandom_range(0, 2) == 0);
        stretch_left = $urandom_range(100, 300);
      end
      stretch_left--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_cycles();
      end
      rsp_ch.ready <= !hold_rsp && (stall_left == 0);
    end
  end

  // one long hold-off of the result side while requests keep coming, so
  // the output register and the sequencer fill up and the input stalls
  initial begin : rsp_hold_off
    hold_rsp = 1'b0;
    wait (sent_cnt >= 300);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // watchdog, several times the slowest correct run
  initial begin : watchdog
    #24_000_000;
    $display("sorted_key_value_table_core_tb failed");
    $finish;
  end

endmodule
